FILE: src/fixed_block_pool_allocator_defines.svh
// Assertion shorthands for the block pool allocator.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// cond holds -> expr holds in the same cycle
`define FBPA_CHECK_NOW(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// cond holds -> expr holds in the next cycle
`define FBPA_CHECK_NEXT(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

FILE: src/fbpa_pkg.sv
package fbpa_pkg;

	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 16;
	localparam int COUNT_W   = 9;
	localparam int ALIGN_W   = 13;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = SIZE_W'(64);
	localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = COUNT_W'(256);
	localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = ADDR_W'(4096);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_SIZE  = 2'd0,
		REG_BLOCK_COUNT = 2'd1,
		REG_POOL_BASE   = 2'd2
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_TOO_LARGE = 3'd1,
		STAT_EMPTY     = 3'd2,
		STAT_UNKNOWN   = 3'd3,
		STAT_NULL      = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHK,
		S_A_RD,
		S_A_GRANT,
		S_A_ALIGN,
		S_A_DIV,
		S_D_DIV,
		S_D_TEST,
		S_S_RD,
		S_S_CHK
	} state_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_STACK,
		IDX_QUOT,
		IDX_SCAN
	} idx_src_t;

	typedef struct packed {
		logic     cfg_open;
		logic     capture;
		logic     clr_step;
		logic     clr_finish;
		logic     mul_load;
		logic     grant;
		logic     div_start;
		logic     div_rel;
		logic     map_rd_scan;
		idx_src_t idx_src;
		logic     scan_init;
		logic     scan_next;
		logic     rel_blk;
		logic     emit;
		status_t  emit_status;
		logic     emit_addr;
		logic     emit_mis;
	} ctl_cmd_t;

	typedef struct packed {
		logic cfg_req;
		logic clr_last;
		logic op;
		logic too_large;
		logic empty;
		logic align_zero;
		logic addr_null;
		logic bs_zero;
		logic offset_zero;
		logic n_zero;
		logic div_done;
		logic div_fit;
		logic map_bit;
		logic full;
		logic scan_last;
	} dp_stat_t;

endpackage

FILE: src/fbpa_ram.sv
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/fbpa_div.sv
module fbpa_div import fbpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ADDR_W-1:0] dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [ADDR_W-1:0] quotient,
	output logic [SIZE_W-1:0] remainder
);

	localparam int STEP_W = $clog2(ADDR_W);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [ADDR_W-1:0] sh_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dsr_q;
	logic [SIZE_W:0]   trial;
	logic              ge;

	// one quotient bit per cycle, restoring form
	assign trial = {rem_q, sh_q[ADDR_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(ADDR_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			sh_q  <= {sh_q[ADDR_W-2:0], ge};
			rem_q <= ge ? SIZE_W'(trial - {1'b0, dsr_q}) : trial[SIZE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = sh_q;
	assign remainder = rem_q;

endmodule

FILE: src/fbpa_ctrl.sv
module fbpa_ctrl import fbpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   cfg_open;

	// hold register writes off while an item is being taken
	assign cfg_open = (state_q == S_CLEAR) || ((state_q == S_IDLE) && !start);
	assign busy     = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		cmd              = '0;
		cmd.cfg_open     = cfg_open;
		cmd.idx_src      = IDX_HOLD;
		cmd.emit_status  = STAT_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					cmd.clr_finish = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.op == OP_ALLOC) begin
					if (stat.too_large) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = STAT_TOO_LARGE;
						state_d         = S_IDLE;
					end else if (stat.empty) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = STAT_EMPTY;
						state_d         = S_IDLE;
					end else begin
						state_d = S_A_RD;
					end
				end else if (stat.addr_null) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = STAT_NULL;
					state_d         = S_IDLE;
				end else if (stat.bs_zero) begin
					// every block starts at the base: walk the map for the lowest one
					if (!stat.offset_zero || stat.n_zero) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = STAT_UNKNOWN;
						state_d         = S_IDLE;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = S_S_RD;
					end
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_rel   = 1'b1;
					state_d       = S_D_DIV;
				end
			end
			S_A_RD: begin
				cmd.mul_load = 1'b1;
				cmd.idx_src  = IDX_STACK;
				state_d      = S_A_GRANT;
			end
			S_A_GRANT: begin
				cmd.grant = 1'b1;
				state_d   = S_A_ALIGN;
			end
			S_A_ALIGN: begin
				if (stat.align_zero) begin
					cmd.emit      = 1'b1;
					cmd.emit_addr = 1'b1;
					state_d       = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_A_DIV;
				end
			end
			S_A_DIV: begin
				if (stat.div_done) begin
					cmd.emit      = 1'b1;
					cmd.emit_addr = 1'b1;
					cmd.emit_mis  = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_D_DIV: begin
				if (stat.div_done) begin
					if (stat.div_fit) begin
						cmd.idx_src = IDX_QUOT;
						state_d     = S_D_TEST;
					end else begin
						cmd.emit        = 1'b1;
						cmd.emit_status = STAT_UNKNOWN;
						state_d         = S_IDLE;
					end
				end
			end
			S_D_TEST: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
				if (stat.map_bit && !stat.full) begin
					cmd.rel_blk = 1'b1;
				end else begin
					cmd.emit_status = STAT_UNKNOWN;
				end
			end
			S_S_RD: begin
				cmd.map_rd_scan = 1'b1;
				cmd.idx_src     = IDX_SCAN;
				state_d         = S_S_CHK;
			end
			S_S_CHK: begin
				if (stat.map_bit) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
					if (stat.full) begin
						cmd.emit_status = STAT_UNKNOWN;
					end else begin
						cmd.rel_blk = 1'b1;
					end
				end else if (stat.scan_last) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = STAT_UNKNOWN;
					state_d         = S_IDLE;
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = S_S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// a register write restarts the restore sweep
		if (stat.cfg_req && cfg_open) begin
			state_d = S_CLEAR;
		end
	end

endmodule

FILE: src/fbpa_dp.sv
module fbpa_dp import fbpa_pkg::*; #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 op,
	input  logic [ADDR_W-1:0]    request_bytes,
	input  logic [ALIGN_W-1:0]   alignment,
	input  logic [ADDR_W-1:0]    release_address,
	input  ctl_cmd_t             cmd,
	output dp_stat_t             stat,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [ADDR_W-1:0]    block_address,
	output logic                 misaligned,
	output logic [COUNT_W-1:0]   used_blocks,
	output logic [COUNT_W-1:0]   available_blocks
);

	localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;
	localparam bit CAP_LIMITS = MAX_BLOCKS <= COUNT_MAX;
	localparam logic [COUNT_W-1:0] NMAX =
		COUNT_W'(CAP_LIMITS ? MAX_BLOCKS : COUNT_MAX);

	logic [SIZE_W-1:0]  bs_q;
	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  base_q;
	logic [COUNT_W-1:0] free_top_q;
	logic [COUNT_W-1:0] used_q;
	logic [IDX_W-1:0]   clr_cnt_q;
	logic [COUNT_W-1:0] scan_q;
	logic               done_q;

	logic               op_q;
	logic [ADDR_W-1:0]  req_q;
	logic [ALIGN_W-1:0] align_q;
	logic [ADDR_W-1:0]  rel_addr_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W+SIZE_W-1:0] prod_q;
	logic [ADDR_W-1:0]  addr_q;
	status_t            out_status_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic               out_mis_q;

	logic               cfg_we;
	logic               cfg_known;
	logic [COUNT_W-1:0] n;
	logic [ADDR_W-1:0]  offset;

	logic               div_done;
	logic [ADDR_W-1:0]  div_quot;
	logic [SIZE_W-1:0]  div_rem;
	logic [ADDR_W-1:0]  div_dividend;
	logic [SIZE_W-1:0]  div_divisor;

	logic               stk_we;
	logic [IDX_W-1:0]   stk_waddr;
	logic [IDX_W-1:0]   stk_wdata;
	logic [IDX_W-1:0]   stk_raddr;
	logic [IDX_W-1:0]   stk_rdata;
	logic               map_we;
	logic [IDX_W-1:0]   map_waddr;
	logic [0:0]         map_wdata;
	logic [IDX_W-1:0]   map_raddr;
	logic [0:0]         map_rdata;

	assign cfg_ready = cmd.cfg_open;
	assign cfg_we    = cfg_valid && cmd.cfg_open;
	assign cfg_known = cfg_index inside {REG_BLOCK_SIZE, REG_BLOCK_COUNT, REG_POOL_BASE};

	assign n      = (count_q > NMAX) ? NMAX : count_q;
	assign offset = rel_addr_q - base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q       <= BLOCK_SIZE_RST;
			count_q    <= BLOCK_COUNT_RST;
			base_q     <= POOL_BASE_RST;
			free_top_q <= '0;
			used_q     <= '0;
			clr_cnt_q  <= '0;
			scan_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_SIZE:  bs_q    <= cfg_data[SIZE_W-1:0];
					REG_BLOCK_COUNT: count_q <= cfg_data[COUNT_W-1:0];
					REG_POOL_BASE:   base_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_we && cfg_known) begin
				clr_cnt_q <= '0;
			end else if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.clr_finish) begin
				free_top_q <= n;
				used_q     <= '0;
			end else if (cmd.grant) begin
				free_top_q <= free_top_q - 1'b1;
				used_q     <= used_q + 1'b1;
			end else if (cmd.rel_blk) begin
				free_top_q <= free_top_q + 1'b1;
				if (used_q != '0) begin
					used_q <= used_q - 1'b1;
				end
			end
			if (cmd.scan_init) begin
				scan_q <= '0;
			end else if (cmd.scan_next) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op;
			req_q      <= request_bytes;
			align_q    <= alignment;
			rel_addr_q <= release_address;
		end
		case (cmd.idx_src)
			IDX_STACK: idx_q <= stk_rdata;
			IDX_QUOT:  idx_q <= IDX_W'(div_quot);
			IDX_SCAN:  idx_q <= IDX_W'(scan_q);
			default: ;
		endcase
		if (cmd.mul_load) begin
			prod_q <= {{SIZE_W{1'b0}}, stk_rdata} * {{IDX_W{1'b0}}, bs_q};
		end
		if (cmd.grant) begin
			addr_q <= base_q + ADDR_W'(prod_q);
		end
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_addr_q   <= cmd.emit_addr ? addr_q : '0;
			out_mis_q    <= cmd.emit_mis && (div_rem != '0);
		end
	end

	// one divider: address modulo alignment, or release offset over block size
	assign div_dividend = cmd.div_rel ? offset : addr_q;
	assign div_divisor  = cmd.div_rel ? bs_q : SIZE_W'(align_q);

	fbpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// free stack: the sweep writes entry i = i, a release pushes at the top
	assign stk_we    = cmd.clr_step || cmd.rel_blk;
	assign stk_waddr = cmd.clr_step ? clr_cnt_q : IDX_W'(free_top_q);
	assign stk_wdata = cmd.clr_step ? clr_cnt_q : idx_q;
	assign stk_raddr = IDX_W'(free_top_q - 1'b1);

	fbpa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_BLOCKS)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign map_we    = cmd.clr_step || cmd.grant || cmd.rel_blk;
	assign map_waddr = cmd.clr_step ? clr_cnt_q : idx_q;
	assign map_wdata = cmd.grant;
	assign map_raddr = cmd.map_rd_scan ? IDX_W'(scan_q) : IDX_W'(div_quot);

	fbpa_ram #(
		.WIDTH (1),
		.DEPTH (MAX_BLOCKS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	always_comb begin
		stat             = '0;
		stat.cfg_req     = cfg_valid && cfg_known;
		stat.clr_last    = clr_cnt_q == IDX_W'(MAX_BLOCKS - 1);
		stat.op          = op_q;
		stat.too_large   = req_q > ADDR_W'(bs_q);
		stat.empty       = free_top_q == '0;
		stat.align_zero  = align_q == '0;
		stat.addr_null   = rel_addr_q == '0;
		stat.bs_zero     = bs_q == '0;
		stat.offset_zero = offset == '0;
		stat.n_zero      = n == '0;
		stat.div_done    = div_done;
		stat.div_fit     = (div_rem == '0) && (div_quot < ADDR_W'(n));
		stat.map_bit     = map_rdata[0];
		stat.full        = CAP_LIMITS && (free_top_q >= NMAX);
		stat.scan_last   = (scan_q + 1'b1) == n;
	end

	assign done             = done_q;
	assign status           = out_status_q;
	assign block_address    = out_addr_q;
	assign misaligned       = out_mis_q;
	assign used_blocks      = used_q;
	assign available_blocks = free_top_q;

endmodule

FILE: src/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator. Raise start with the operands while busy is low; the item is
// taken at that edge and busy stays high until its result. Exactly one result per item appears
// for a single cycle with done high and cannot be held off, so capture it then; a new item may be
// started in that same cycle. The longer paths, an allocate with nonzero alignment and a
// deallocate, go through the shared radix-2 divider (one quotient bit per cycle over 32 bits)
// that forms the alignment remainder and the address-to-block index. With a block size of zero a
// deallocate walks the allocated map instead, reading and then testing the entry of each block
// visited. After reset and after every register write busy stays high for a restore sweep that
// rebuilds the free stack and clears the allocated map, one entry a cycle. Register writes are
// taken only while sweeping, or while idle with start low.
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator import fbpa_pkg::*; #(
	parameter int MAX_BLOCKS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 op,
	input  logic [ADDR_W-1:0]    request_bytes,
	input  logic [ALIGN_W-1:0]   alignment,
	input  logic [ADDR_W-1:0]    release_address,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [ADDR_W-1:0]    block_address,
	output logic                 misaligned,
	output logic [COUNT_W-1:0]   used_blocks,
	output logic [COUNT_W-1:0]   available_blocks,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	fbpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	fbpa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.op               (op),
		.request_bytes    (request_bytes),
		.alignment        (alignment),
		.release_address  (release_address),
		.cmd              (cmd),
		.stat             (stat),
		.done             (done),
		.status           (status),
		.block_address    (block_address),
		.misaligned       (misaligned),
		.used_blocks      (used_blocks),
		.available_blocks (available_blocks)
	);

	`FBPA_CHECK_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`FBPA_CHECK_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`FBPA_CHECK_NOW(a_fail_no_grant, done && (status != STAT_OK),
		(block_address == '0) && !misaligned, "failed item reports a block")
	`FBPA_CHECK_NOW(a_fail_counts_hold, done && (status != STAT_OK),
		$stable(used_blocks) && $stable(available_blocks), "failed item changed block counts")

endmodule

FILE: bench/fixed_block_pool_allocator_tb.sv
module fixed_block_pool_allocator_tb import fbpa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_MAX = 256;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		logic               op;
		logic [ADDR_W-1:0]  req;
		logic [ALIGN_W-1:0] aln;
		logic [ADDR_W-1:0]  rel;
	} pool_op_t;

	typedef struct packed {
		status_t            st;
		logic [ADDR_W-1:0]  addr;
		logic               mis;
		logic [COUNT_W-1:0] used;
		logic [COUNT_W-1:0] avail;
	} pool_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 op = OP_ALLOC;
	logic [ADDR_W-1:0]    request_bytes = '0;
	logic [ALIGN_W-1:0]   alignment = '0;
	logic [ADDR_W-1:0]    release_address = '0;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [ADDR_W-1:0]    block_address;
	logic                 misaligned;
	logic [COUNT_W-1:0]   used_blocks;
	logic [COUNT_W-1:0]   available_blocks;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_BLOCK_SIZE;
	logic [ADDR_W-1:0]    cfg_data = '0;

	fixed_block_pool_allocator #(.MAX_BLOCKS(POOL_MAX)) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.op               (op),
		.request_bytes    (request_bytes),
		.alignment        (alignment),
		.release_address  (release_address),
		.done             (done),
		.status           (status),
		.block_address    (block_address),
		.misaligned       (misaligned),
		.used_blocks      (used_blocks),
		.available_blocks (available_blocks),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// predicted pool state
	logic [SIZE_W-1:0]  cfg_size;
	logic [COUNT_W-1:0] cfg_count;
	logic [ADDR_W-1:0]  cfg_base;
	logic [7:0]         free_stk [POOL_MAX];
	logic [COUNT_W-1:0] free_cnt;
	logic [POOL_MAX-1:0] taken_map;
	logic [COUNT_W-1:0] used_cnt;

	// stimulus side view of the current settings
	logic [SIZE_W-1:0]  gen_size = BLOCK_SIZE_RST;
	logic [COUNT_W-1:0] gen_count = BLOCK_COUNT_RST;
	logic [ADDR_W-1:0]  gen_base = POOL_BASE_RST;

	pool_op_t    pending_ops [$];
	pool_reply_t replies_due [$];
	pool_op_t    drv_item;
	pool_reply_t got_reply;

	int issued = 0;
	int accepted = 0;
	int cfg_xfers = 0;
	int gap_pct = 0;
	int quiet = 0;
	int errors = 0;
	int grants = 0;
	int releases = 0;
	int refusals = 0;
	int settings_seen = 0;

	function automatic int pool_span();
		return (cfg_count > COUNT_W'(POOL_MAX)) ? POOL_MAX : int'(cfg_count);
	endfunction

	function automatic logic [ADDR_W-1:0] block_addr(int idx);
		return cfg_base + ADDR_W'(idx) * {16'd0, cfg_size};
	endfunction

	function automatic void restore_pool();
		for (int i = 0; i < POOL_MAX; i++) begin
			free_stk[i] = i[7:0];
		end
		taken_map = '0;
		free_cnt = COUNT_W'(pool_span());
		used_cnt = '0;
	endfunction

	function automatic pool_reply_t apply_request(pool_op_t it);
		pool_reply_t r;
		int slot;
		int n;
		int i;
		bit hit;
		r.st = STAT_OK;
		r.addr = '0;
		r.mis = 1'b0;
		if (it.op == OP_ALLOC) begin
			if (it.req > {16'd0, cfg_size}) begin
				r.st = STAT_TOO_LARGE;
			end else if (free_cnt == 0) begin
				r.st = STAT_EMPTY;
			end else begin
				free_cnt = free_cnt - 1'b1;
				slot = int'(free_stk[free_cnt[7:0]]);
				taken_map[slot] = 1'b1;
				used_cnt = used_cnt + 1'b1;
				r.addr = block_addr(slot);
				r.mis = (it.aln != 0) && ((r.addr % {19'd0, it.aln}) != 0);
			end
		end else if (it.rel == 0) begin
			r.st = STAT_NULL;
		end else begin
			n = pool_span();
			hit = 1'b0;
			i = 0;
			// first allocated block whose start matches, lowest index wins
			while (i < n && !hit) begin
				if (taken_map[i] && block_addr(i) == it.rel)
					hit = 1'b1;
				else
					i++;
			end
			if (!hit || free_cnt >= COUNT_W'(POOL_MAX)) begin
				r.st = STAT_UNKNOWN;
			end else begin
				taken_map[i] = 1'b0;
				if (used_cnt > 0)
					used_cnt = used_cnt - 1'b1;
				free_stk[free_cnt[7:0]] = i[7:0];
				free_cnt = free_cnt + 1'b1;
			end
		end
		r.used = used_cnt;
		r.avail = free_cnt;
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		errors++;
		if (errors <= 40)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// driver: hold an item until its transfer, then advance or drop start
	always @(negedge clk) begin
		if (!(start && issued != accepted)) begin
			if (arst_n && pending_ops.size() != 0 && $urandom_range(99) >= gap_pct) begin
				drv_item = pending_ops.pop_front();
				op <= drv_item.op;
				request_bytes <= drv_item.req;
				alignment <= drv_item.aln;
				release_address <= drv_item.rel;
				start <= 1'b1;
				issued = issued + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_size = BLOCK_SIZE_RST;
			cfg_count = BLOCK_COUNT_RST;
			cfg_base = POOL_BASE_RST;
			restore_pool();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BLOCK_SIZE: cfg_size = cfg_data[SIZE_W-1:0];
					REG_BLOCK_COUNT: cfg_count = cfg_data[COUNT_W-1:0];
					REG_POOL_BASE: cfg_base = cfg_data;
					default: ;
				endcase
				restore_pool();
				cfg_xfers++;
			end
			if (done) begin
				if (replies_due.size() == 0) begin
					flag_mismatch("result with no request outstanding");
				end else begin
					got_reply = replies_due.pop_front();
					if (status !== got_reply.st)
						flag_mismatch($sformatf("status %0d, want %0d", status, got_reply.st));
					if (block_address !== got_reply.addr)
						flag_mismatch($sformatf("block_address %h, want %h",
							block_address, got_reply.addr));
					if (misaligned !== got_reply.mis)
						flag_mismatch($sformatf("misaligned %b, want %b",
							misaligned, got_reply.mis));
					if (used_blocks !== got_reply.used)
						flag_mismatch($sformatf("used_blocks %0d, want %0d",
							used_blocks, got_reply.used));
					if (available_blocks !== got_reply.avail)
						flag_mismatch($sformatf("available_blocks %0d, want %0d",
							available_blocks, got_reply.avail));
				end
			end
			if (start && !busy) begin
				got_reply = apply_request({op, request_bytes, alignment, release_address});
				replies_due.insert(replies_due.size(), got_reply);
				if (got_reply.st != STAT_OK)
					refusals++;
				else if (op == OP_ALLOC)
					grants++;
				else
					releases++;
				accepted++;
			end
			if ((cfg_valid && cfg_ready) || done || (start && !busy))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Stalled after %0d requests with %0d results pending", accepted,
					replies_due.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic push_alloc(logic [ADDR_W-1:0] req, logic [ALIGN_W-1:0] aln);
		pool_op_t it;
		it = {OP_ALLOC, req, aln, ADDR_W'($urandom)};
		pending_ops.insert(pending_ops.size(), it);
	endtask

	task automatic push_free(logic [ADDR_W-1:0] rel);
		pool_op_t it;
		it = {OP_FREE, ADDR_W'($urandom), ALIGN_W'($urandom), rel};
		pending_ops.insert(pending_ops.size(), it);
	endtask

	task automatic push_random(int alloc_pct);
		pool_op_t it;
		int pick;
		int span;
		logic [ADDR_W-1:0] k;
		it.op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
		it.req = $urandom;
		it.aln = ALIGN_W'($urandom_range(4096));
		it.rel = $urandom;
		pick = $urandom_range(9);
		if (it.op == OP_ALLOC) begin
			case (pick)
				0, 1, 2, 3, 4, 5, 6: it.req = $urandom_range({16'd0, gen_size});
				7: it.req = {16'd0, gen_size};
				8: it.req = {16'd0, gen_size} + 32'd1;
				default: ;
			endcase
			pick = $urandom_range(9);
			if (pick < 3)
				it.aln = '0;
			else if (pick < 7)
				it.aln = ALIGN_W'(1) << $urandom_range(12);
		end else begin
			span = (gen_count > COUNT_W'(POOL_MAX)) ? POOL_MAX : int'(gen_count);
			if (span == 0)
				span = 4;
			k = $urandom_range(span - 1);
			case (pick)
				0, 1, 2, 3, 4, 5, 6: it.rel = gen_base + k * {16'd0, gen_size};
				7: begin
					if ($urandom_range(1))
						it.rel = gen_base + k * {16'd0, gen_size} + 32'd1;
					else
						it.rel = gen_base + k * {16'd0, gen_size} - 32'd1;
				end
				8: it.rel = '0;
				default: ;
			endcase
		end
		pending_ops.insert(pending_ops.size(), it);
	endtask

	task automatic wait_idle();
		while (pending_ops.size() != 0 || replies_due.size() != 0 || issued != accepted)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [ADDR_W-1:0] data);
		int seen;
		seen = cfg_xfers;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		while (cfg_xfers == seen)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// upper data bits beyond a register's width carry junk
	task automatic set_pool(logic [SIZE_W-1:0] size, logic [COUNT_W-1:0] count,
			logic [ADDR_W-1:0] base);
		wait_idle();
		write_reg(REG_BLOCK_SIZE, {16'($urandom), size});
		write_reg(REG_BLOCK_COUNT, {23'($urandom), count});
		write_reg(REG_POOL_BASE, base);
		gen_size = size;
		gen_count = count;
		gen_base = base;
		settings_seen++;
	endtask

	task automatic run_phase(logic [SIZE_W-1:0] size, logic [COUNT_W-1:0] count,
			logic [ADDR_W-1:0] base, int n_items, int alloc_pct, int gap, bit pause_mid);
		set_pool(size, count, base);
		gap_pct = gap;
		for (int i = 0; i < n_items; i++) begin
			// hold the sender until the pool has answered everything so far
			if (pause_mid && i == n_items / 2)
				wait_idle();
			push_random(alloc_pct);
		end
	endtask

	initial begin
		int gaps [3];
		gaps = '{0, 58, 15};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: top of stack is the last block
		push_alloc(32'd0, 13'd0);
		push_alloc(32'd64, 13'd4096);
		push_alloc(32'd65, 13'd1);
		push_alloc(32'hFFFF_FFFF, 13'd0);
		push_alloc(32'd33, 13'd3);
		push_free(32'd0);
		push_free(32'd4096 + 32'd255 * 32'd64);
		push_free(32'd4096 + 32'd255 * 32'd64);
		push_free(32'd4096 + 32'd254 * 32'd64 + 32'd1);
		// two blocks: run dry, size check ahead of empty check
		set_pool(16'd8, 9'd2, 32'd100);
		push_alloc(32'd8, 13'd8);
		push_alloc(32'd0, 13'd0);
		push_alloc(32'd0, 13'd0);
		push_alloc(32'd9, 13'd0);
		push_free(32'd100);
		// no blocks at all
		set_pool(16'd64, 9'd0, 32'd4096);
		push_alloc(32'd1, 13'd0);
		push_free(32'd4096);
		// zero size: every block at the base, release takes the lowest index
		set_pool(16'd0, 9'd4, 32'd500);
		push_alloc(32'd0, 13'd0);
		push_alloc(32'd0, 13'd0);
		push_alloc(32'd1, 13'd0);
		push_free(32'd500);
		push_free(32'd500);
		push_free(32'd500);
		// block zero at the null address
		set_pool(16'd16, 9'd1, 32'd0);
		push_alloc(32'd16, 13'd16);
		push_free(32'd0);
		// oversized count saturates, addresses wrap
		set_pool(16'd65535, 9'd511, 32'hFFFF_FFF0);
		push_alloc(32'd65535, 13'd4096);
		push_free(32'hFFFF_FFF0 + 32'd255 * 32'd65535);

		run_phase(16'd64, 9'd256, 32'd4096, 300, 55, 0, 1'b1);
		run_phase(16'd65535, 9'd256, 32'hFFFF_0000, 200, 60, 58, 1'b0);
		run_phase(16'd1, 9'd1, 32'd1, 120, 50, 15, 1'b0);
		run_phase(16'd0, 9'd8, $urandom, 100, 55, 0, 1'b0);
		run_phase(16'd64, 9'd0, $urandom, 40, 50, 58, 1'b0);
		run_phase(SIZE_W'($urandom_range(4096, 1)), 9'd511, $urandom, 200, 55, 15, 1'b0);
		run_phase(16'd16, 9'd4, 32'd0, 100, 50, 0, 1'b0);
		for (int p = 0; p < 5; p++) begin
			run_phase(($urandom_range(3) == 0) ? SIZE_W'($urandom) :
				SIZE_W'($urandom_range(256, 1)), COUNT_W'($urandom_range(32, 1)),
				$urandom, 180, $urandom_range(70, 50), gaps[p % 3], 1'b0);
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (replies_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", replies_due.size()));
		$display("Ran %0d requests over %0d pool settings, errors %0d", accepted,
			settings_seen, errors);
		$display("  %0d grants, %0d releases, %0d refused or ignored", grants, releases,
			refusals);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
